// File: hdl/ewg_pkg.sv
// ----------------------------------------------------------------------------
// ewg_pkg
// Shared widths, register codes, configuration struct and the CORDIC
// arctangent table of the elliptical waypoint generator.
// ----------------------------------------------------------------------------
package ewg_pkg;

	localparam int PHASE_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 17;
	localparam int HEIGHT_W  = 16;
	localparam int CORDIC_W  = 34;
	localparam int ANGLE_W   = 33;
	localparam int Q15_W     = 17;
	localparam int ITERS     = 16;
	localparam int ITER_W    = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd4;

	// CORDIC start vector, 1/K in Q30
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// ellipse shape seen by the back end
	typedef struct packed {
		logic [CFG_W-1:0]           radius_x;
		logic [CFG_W-1:0]           radius_y;
		logic signed [HEIGHT_W-1:0] height;
	} shape_cfg_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [ANGLE_W-1:0] atan_lookup(input logic [ITER_W-1:0] i);
		logic signed [ANGLE_W-1:0] a;
		case (i)
			4'd0:    a = 33'sh020000000;
			4'd1:    a = 33'sh012E4051E;
			4'd2:    a = 33'sh009FB385B;
			4'd3:    a = 33'sh0051111D4;
			4'd4:    a = 33'sh0028B0D43;
			4'd5:    a = 33'sh00145D7E1;
			4'd6:    a = 33'sh000A2F61E;
			4'd7:    a = 33'sh000517C55;
			4'd8:    a = 33'sh00028BE53;
			4'd9:    a = 33'sh000145F2F;
			4'd10:   a = 33'sh0000A2F98;
			4'd11:   a = 33'sh0000517CC;
			4'd12:   a = 33'sh000028BE6;
			4'd13:   a = 33'sh0000145F3;
			4'd14:   a = 33'sh00000A2FA;
			default: a = 33'sh00000517D;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/ewg_front.sv
// ----------------------------------------------------------------------------
// ewg_front
// Accepts tick transactions, runs the phase accumulator and pushes each new
// phase into the work queue.
// ----------------------------------------------------------------------------
module ewg_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,
	input  logic [ewg_pkg::PHASE_W-1:0]  phase_step,
	input  logic [ewg_pkg::PHASE_W-1:0]  start_phase,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [ewg_pkg::PHASE_W-1:0]  q_phase
);
	import ewg_pkg::*;

	logic                active_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [PHASE_W-1:0]  base;
	logic                accept;

	// stall while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// reload start phase on first tick or restart, then advance modulo a turn
	assign base    = (restart || !active_q) ? start_phase : phase_q;
	assign q_phase = base + phase_step;
	assign q_push  = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			phase_q  <= q_phase;
		end
	end

endmodule

// File: hdl/ewg_queue.sv
// ----------------------------------------------------------------------------
// ewg_queue
// Short FIFO of pending phases between the front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module ewg_queue #(
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [ewg_pkg::PHASE_W-1:0]  push_data,
	output logic                         full,
	input  logic                         pop,
	output logic [ewg_pkg::PHASE_W-1:0]  pop_data,
	output logic                         empty
);
	import ewg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PHASE_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule

// File: hdl/ewg_back.sv
// ----------------------------------------------------------------------------
// ewg_back
// Iterative CORDIC for sine and cosine of a queued phase, then scaling by the
// ellipse radii through one shared multiplier into the output register.
// ----------------------------------------------------------------------------
module ewg_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ewg_pkg::shape_cfg_t                 shape,
	input  logic                                q_empty,
	input  logic [ewg_pkg::PHASE_W-1:0]         q_phase,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ewg_pkg::COORD_W-1:0]  waypoint_x,
	output logic signed [ewg_pkg::COORD_W-1:0]  waypoint_y,
	output logic signed [ewg_pkg::HEIGHT_W-1:0] waypoint_z
);
	import ewg_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_ROUND, S_MULX, S_MULY} state_t;

	localparam int PROD_W = 2 * Q15_W;

	state_t                       state_q;
	logic [ITER_W-1:0]            iter_q;
	logic                         flip_q;
	logic signed [CORDIC_W-1:0]   x_q;
	logic signed [CORDIC_W-1:0]   y_q;
	logic signed [ANGLE_W-1:0]    z_q;
	logic signed [Q15_W-1:0]      cos_q;
	logic signed [Q15_W-1:0]      sin_q;
	logic signed [COORD_W-1:0]    wx_q;
	logic                         out_valid_q;
	logic signed [COORD_W-1:0]    waypoint_x_q;
	logic signed [COORD_W-1:0]    waypoint_y_q;
	logic signed [HEIGHT_W-1:0]   waypoint_z_q;

	logic signed [PHASE_W:0]      p_ext;
	logic signed [PHASE_W:0]      p_fold;
	logic                         fold;
	logic signed [ANGLE_W-1:0]    angle;
	logic signed [CORDIC_W-1:0]   dx;
	logic signed [CORDIC_W-1:0]   dy;
	logic signed [ANGLE_W-1:0]    at;
	logic signed [Q15_W-1:0]      mul_a;
	logic signed [Q15_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]     prod;
	logic signed [PROD_W-1:0]     scaled;
	logic                         out_free;

	// round Q30 to Q15, clamp to plus or minus one, negate for a folded angle
	function automatic logic signed [Q15_W-1:0] round_q15(input logic signed [CORDIC_W-1:0] v,
			input logic neg);
		logic signed [CORDIC_W-1:0] r;
		logic signed [Q15_W-1:0]    c;
		r = (v + CORDIC_W'(16384)) >>> 15;
		if (r > CORDIC_W'(32768)) begin
			c = 17'sd32768;
		end else if (r < -CORDIC_W'(32768)) begin
			c = -17'sd32768;
		end else begin
			c = r[Q15_W-1:0];
		end
		return neg ? -c : c;
	endfunction

	// fold angles beyond a quarter turn by a half turn
	assign p_ext = (PHASE_W + 1)'($signed(q_phase));
	always_comb begin
		p_fold = p_ext;
		fold   = 1'b0;
		if (p_ext > 17'sd16384) begin
			p_fold = p_ext - 17'sd32768;
			fold   = 1'b1;
		end else if (p_ext < -17'sd16384) begin
			p_fold = p_ext + 17'sd32768;
			fold   = 1'b1;
		end
	end
	assign angle = {p_fold, 16'b0};

	// one CORDIC micro-rotation
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = atan_lookup(iter_q);

	// shared radius multiplier
	assign mul_a  = (state_q == S_MULX) ? $signed({1'b0, shape.radius_x})
	                                    : $signed({1'b0, shape.radius_y});
	assign mul_b  = (state_q == S_MULX) ? cos_q : sin_q;
	assign prod   = mul_a * mul_b;
	assign scaled = prod >>> 15;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			iter_q       <= '0;
			flip_q       <= 1'b0;
			x_q          <= '0;
			y_q          <= '0;
			z_q          <= '0;
			cos_q        <= '0;
			sin_q        <= '0;
			wx_q         <= '0;
			waypoint_x_q <= '0;
			waypoint_y_q <= '0;
			waypoint_z_q <= '0;
		end else begin
			// drop the accepted waypoint unless a new one replaces it
			if (out_valid_q && !out_stall && (state_q != S_MULY)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						z_q     <= angle;
						flip_q  <= fold;
						iter_q  <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (!z_q[ANGLE_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(ITERS - 1)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					cos_q   <= round_q15(x_q, flip_q);
					sin_q   <= round_q15(y_q, flip_q);
					state_q <= S_MULX;
				end
				S_MULX: begin
					wx_q    <= scaled[COORD_W-1:0];
					state_q <= S_MULY;
				end
				S_MULY: begin
					// hold until the output register is free
					if (out_free) begin
						waypoint_x_q <= wx_q;
						waypoint_y_q <= scaled[COORD_W-1:0];
						waypoint_z_q <= shape.height;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign waypoint_x = waypoint_x_q;
	assign waypoint_y = waypoint_y_q;
	assign waypoint_z = waypoint_z_q;

	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_RUN) && (iter_q == '0))
		else $error("pop did not start a CORDIC run");
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (iter_q == ITER_W'(ITERS - 1)) |=> state_q == S_ROUND)
		else $error("CORDIC run did not end after the last iteration");
	a_out_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_MULY)
		else $error("output loaded outside the final multiply");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("pending waypoint dropped");

endmodule

// File: hdl/ellipse_waypoint_generator_unit.sv
// ----------------------------------------------------------------------------
// ellipse_waypoint_generator_unit
// Phase accumulator driving an iterative CORDIC; each tick yields one point
// on an ellipse scaled by the configured radii at the configured height.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------
//  tick in | in_valid / in_stall          | restart
//  out     | out_valid / out_stall        | waypoint_x, waypoint_y, waypoint_z
//  config  | cfg_wr_en (no wait)          | cfg_index, cfg_data
//
// In the back end each transaction passes through a load, 16 CORDIC
// iterations on the shared shift-add unit, a rounding step and the x and y
// multiply states on the shared radius multiplier. The front end and the
// queue take ticks while the back end works; in_stall rises only with the
// queue full. A finished waypoint waits in the output register while the
// next one is computed. Reset clears the accumulator, queue and output valid.
// ----------------------------------------------------------------------------
module ellipse_waypoint_generator_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ewg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ewg_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ewg_pkg::COORD_W-1:0]  waypoint_x,
	output logic signed [ewg_pkg::COORD_W-1:0]  waypoint_y,
	output logic signed [ewg_pkg::HEIGHT_W-1:0] waypoint_z
);
	import ewg_pkg::*;

	shape_cfg_t         shape_q;
	logic [CFG_W-1:0]   phase_step_q;
	logic [CFG_W-1:0]   start_phase_q;

	logic               q_push;
	logic [PHASE_W-1:0] q_push_phase;
	logic               q_full;
	logic               q_pop;
	logic [PHASE_W-1:0] q_pop_phase;
	logic               q_empty;

	// configuration registers, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q       <= '0;
			phase_step_q  <= '0;
			start_phase_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RADIUS_X:    shape_q.radius_x <= cfg_data;
				REG_RADIUS_Y:    shape_q.radius_y <= cfg_data;
				REG_HEIGHT:      shape_q.height   <= $signed(cfg_data);
				REG_PHASE_STEP:  phase_step_q     <= cfg_data;
				REG_START_PHASE: start_phase_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ewg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.phase_step  (phase_step_q),
		.start_phase (start_phase_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_phase     (q_push_phase)
	);

	ewg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_phase),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_phase),
		.empty     (q_empty)
	);

	ewg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.shape      (shape_q),
		.q_empty    (q_empty),
		.q_phase    (q_pop_phase),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.waypoint_x (waypoint_x),
		.waypoint_y (waypoint_y),
		.waypoint_z (waypoint_z)
	);

endmodule
